// ===== hdl/fwbs_pkg.sv =====
// ----------------------------------------------------------------------------
// fwbs_pkg
// Shared constants, types and the state encoding of the fixed-weight sampler.
// ----------------------------------------------------------------------------
package fwbs_pkg;

  localparam int NUM_COEFFS = 256;
  localparam int WORD_BITS  = 64;
  localparam int POS_W      = 6;
  localparam int NUM_WORDS  = (NUM_COEFFS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W      = $clog2(NUM_WORDS + 1);
  localparam int WALK_W     = $clog2(NUM_COEFFS + 1);
  localparam int SAMPLE_W   = 8;
  localparam int WEIGHT_W   = 9;
  localparam int WIDX_W     = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd64;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    waddr_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_DUMP
  } state_t;

  // sequencer -> store: restart and word readout
  typedef struct packed {
    logic   restart;
    logic   dump_re;
    waddr_t dump_addr;
  } core_ctl_t;

endpackage

// ===== hdl/fwbs_if.sv =====
// ----------------------------------------------------------------------------
// fwbs_if
// Valid/ready channels of the sampler: sample bytes in, coefficient words out.
// ----------------------------------------------------------------------------
interface fwbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [fwbs_pkg::SAMPLE_W-1:0] sample_byte;

  modport source (output valid, output sample_byte, input ready);
  modport sink   (input valid, input sample_byte, output ready);
endinterface

interface fwbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [fwbs_pkg::WORD_BITS-1:0] coeff_word;
  logic [fwbs_pkg::WIDX_W-1:0] word_index;
  logic                        last_word;

  modport source (output valid, output coeff_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input coeff_word, input word_index, input last_word,
                  output ready);
endinterface

// ===== hdl/fixed_weight_binary_sampler.sv =====
// ----------------------------------------------------------------------------
// fixed_weight_binary_sampler
// Builds a binary polynomial of fixed weight from a stream of random bytes.
// ----------------------------------------------------------------------------
// Takes one random byte per item and one item per cycle. A byte above the
// walk index is dropped; otherwise the coefficient at the walk index copies
// the coefficient at the byte's position, that position is set to one and the
// walk index steps. The store is two 64-bit-word RAMs (positions picked by a
// byte, and values copied to the walk), the current walk word is a register,
// and a one-entry forward per RAM covers the registered read, so items flow
// back to back. After the item that completes a polynomial, input is held off
// while the words are read out over the shared RAM read port, and for longer
// if out_ch.ready stalls. Words leave lowest first with word_index and
// last_word; the next polynomial starts right after. Per-word valid bits give
// the cleared store at once, so there is no clearing pass after reset. Writing
// cfg_wdata (the weight, clamped to 1..NUM_COEFFS) restarts the walk; write it
// only while idle.
// ----------------------------------------------------------------------------
module fixed_weight_binary_sampler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fwbs_pkg::WEIGHT_W-1:0] cfg_wdata,
  fwbs_in_if.sink                       in_ch,
  fwbs_out_if.source                    out_ch
);
  import fwbs_pkg::*;

  logic      in_ready;
  logic      acc;
  logic      final_acc;
  word_t     rd_word;
  core_ctl_t ctl;

  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid & in_ready;

  // walk index, store RAMs, per-item read-modify-write
  fwbs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .sample_byte (in_ch.sample_byte),
    .ctl         (ctl),
    .final_acc   (final_acc),
    .rd_word     (rd_word)
  );

  // end-of-polynomial readout and output register
  fwbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .final_acc (final_acc),
    .rd_word   (rd_word),
    .in_ready  (in_ready),
    .ctl       (ctl),
    .out_ch    (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.coeff_word))
    else $error("stalled output word changed");

  a_last_is_top_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_word |-> out_ch.word_index == WIDX_W'(NUM_WORDS - 1))
    else $error("last word flag on a lower word");

  a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !acc)
    else $error("weight written together with an item");
`endif

endmodule

// ===== hdl/fwbs_ram.sv =====
// ----------------------------------------------------------------------------
// fwbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/fwbs_core.sv =====
// ----------------------------------------------------------------------------
// fwbs_core
// Walk index, coefficient store and the per-item read-modify-write.
// ----------------------------------------------------------------------------
module fwbs_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fwbs_pkg::WEIGHT_W-1:0] cfg_wdata,
  input  logic                          acc,
  input  logic [fwbs_pkg::SAMPLE_W-1:0] sample_byte,
  input  fwbs_pkg::core_ctl_t           ctl,
  output logic                          final_acc,
  output fwbs_pkg::word_t               rd_word
);
  import fwbs_pkg::*;

  localparam int CMP_W = (WALK_W > SAMPLE_W) ? WALK_W : SAMPLE_W;

  // clamp weight to 1..N, start index is N minus that
  function automatic logic [WALK_W-1:0] walk_start(input logic [WEIGHT_W-1:0] w);
    logic [WALK_W-1:0] eff;
    if (w == '0) begin
      eff = WALK_W'(1);
    end else if (int'(w) > NUM_COEFFS) begin
      eff = WALK_W'(NUM_COEFFS);
    end else begin
      eff = WALK_W'(w);
    end
    return WALK_W'(NUM_COEFFS) - eff;
  endfunction

  logic [WEIGHT_W-1:0] weight_r;
  logic [WALK_W-1:0]   walk_r, walk_nxt;
  logic                restart;
  logic                rej, go;
  waddr_t              b_word, ra;
  logic                re;

  // item in flight (registered from an accepted byte that was not dropped)
  logic                s1_vld_r;
  waddr_t              s1_bw_r, s1_ww_r;
  logic [POS_W-1:0]    s1_bpos_r, s1_wpos_r;
  logic                s1_flush_r;

  // memory A: positions picked by a byte; memory B: values copied to the walk
  word_t               rd_a, rd_b;
  logic                va_cap_r, vb_cap_r;
  logic [NUM_WORDS-1:0] vld_a_r, vld_a_nxt, vld_b_r, vld_b_nxt;
  logic                fa_vld_r, fb_vld_r;
  waddr_t              fa_addr_r, fb_addr_r;
  word_t               fa_data_r, fb_data_r;
  word_t               cur_r, cur_nxt;

  word_t               a_cur, b_mem, b_cur, a_new, cur_new;
  logic                sel_bit;
  logic                we_a, we_b;

  assign restart = cfg_we | ctl.restart;
  assign rej     = CMP_W'(sample_byte) > CMP_W'(walk_r);
  assign go      = acc & ~rej;
  assign b_word  = ADDR_W'(sample_byte >> POS_W);
  assign final_acc = go && (walk_r == WALK_W'(NUM_COEFFS - 1));

  assign re = acc | ctl.dump_re;
  assign ra = ctl.dump_re ? ctl.dump_addr : b_word;

  always_comb begin
    if (restart) begin
      walk_nxt = walk_start(cfg_we ? cfg_wdata : weight_r);
    end else if (go) begin
      walk_nxt = walk_r + WALK_W'(1);
    end else begin
      walk_nxt = walk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RST;
      walk_r   <= walk_start(WEIGHT_RST);
    end else begin
      if (cfg_we) begin
        weight_r <= cfg_wdata;
      end
      walk_r <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_bw_r    <= b_word;
      s1_ww_r    <= ADDR_W'(walk_r >> POS_W);
      s1_bpos_r  <= sample_byte[POS_W-1:0];
      s1_wpos_r  <= walk_r[POS_W-1:0];
      s1_flush_r <= (walk_r[POS_W-1:0] == POS_W'(WORD_BITS - 1)) ||
                    (walk_r == WALK_W'(NUM_COEFFS - 1));
    end
    if (re) begin
      va_cap_r <= vld_a_r[ra];
      vb_cap_r <= vld_b_r[ra];
    end
  end

  // the forward registers hold the latest write, which the read taken at the
  // same edge missed
  always_comb begin
    a_cur = (fa_vld_r && fa_addr_r == s1_bw_r) ? fa_data_r : (va_cap_r ? rd_a : '0);
    b_mem = (fb_vld_r && fb_addr_r == s1_bw_r) ? fb_data_r : (vb_cap_r ? rd_b : '0);
    b_cur = (s1_bw_r == s1_ww_r) ? cur_r : b_mem;
    sel_bit = a_cur[s1_bpos_r] | b_cur[s1_bpos_r];
    a_new   = a_cur | (word_t'(1) << s1_bpos_r);
    cur_new = cur_r | (word_t'(sel_bit) << s1_wpos_r);
  end

  assign we_a = s1_vld_r;
  assign we_b = s1_vld_r & s1_flush_r;

  always_comb begin
    if (restart || we_b) begin
      cur_nxt = '0;
    end else if (s1_vld_r) begin
      cur_nxt = cur_new;
    end else begin
      cur_nxt = cur_r;
    end
  end

  always_comb begin
    vld_a_nxt = vld_a_r;
    vld_b_nxt = vld_b_r;
    if (restart) begin
      vld_a_nxt = '0;
      vld_b_nxt = '0;
    end else begin
      if (we_a) begin
        vld_a_nxt[s1_bw_r] = 1'b1;
      end
      if (we_b) begin
        vld_b_nxt[s1_ww_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      vld_a_r  <= '0;
      vld_b_r  <= '0;
      fa_vld_r <= 1'b0;
      fb_vld_r <= 1'b0;
    end else begin
      cur_r    <= cur_nxt;
      vld_a_r  <= vld_a_nxt;
      vld_b_r  <= vld_b_nxt;
      fa_vld_r <= restart ? 1'b0 : (fa_vld_r | we_a);
      fb_vld_r <= restart ? 1'b0 : (fb_vld_r | we_b);
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      fa_addr_r <= s1_bw_r;
      fa_data_r <= a_new;
    end
    if (we_b) begin
      fb_addr_r <= s1_ww_r;
      fb_data_r <= cur_new;
    end
  end

  fwbs_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (s1_bw_r),
    .wdata (a_new),
    .re    (re),
    .raddr (ra),
    .rdata (rd_a)
  );

  fwbs_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (s1_ww_r),
    .wdata (cur_new),
    .re    (re),
    .raddr (ra),
    .rdata (rd_b)
  );

  assign rd_word = (va_cap_r ? rd_a : '0) | (vb_cap_r ? rd_b : '0);

`ifndef NO_ASSERTIONS
  a_byte_not_past_walk: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> s1_bw_r <= s1_ww_r)
    else $error("picked position lies above the walk word");

  a_no_dump_during_item: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dump_re |-> !s1_vld_r && !acc)
    else $error("word readout overlaps an item update");

  a_restart_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> walk_r < WALK_W'(NUM_COEFFS))
    else $error("walk index restarted out of range");
`endif

endmodule

// ===== hdl/fwbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwbs_ctrl
// Polynomial sequencer: drains the last item, reads out the words, restarts.
// ----------------------------------------------------------------------------
module fwbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                final_acc,
  input  fwbs_pkg::word_t     rd_word,
  output logic                in_ready,
  output fwbs_pkg::core_ctl_t ctl,
  fwbs_out_if.source          out_ch
);
  import fwbs_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              d1_vld_r;
  waddr_t            d1_idx_r;
  logic              d1_move, issue, done;

  logic              out_vld_r;
  word_t             out_word_r;
  logic [WIDX_W-1:0] out_idx_r;
  logic              out_last_r;

  assign d1_move = d1_vld_r && (!out_vld_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (final_acc) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DUMP;
      ST_DUMP: begin
        if (done) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    done     = 1'b0;
    case (state_r)
      ST_RUN: in_ready = !d1_vld_r;
      ST_DRAIN: ;
      ST_DUMP: begin
        issue = (cnt_r != CNT_W'(NUM_WORDS)) && (!d1_vld_r || d1_move);
        done  = (cnt_r == CNT_W'(NUM_WORDS)) && (!d1_vld_r || d1_move);
      end
      default: ;
    endcase
    ctl.restart   = done;
    ctl.dump_re   = issue;
    ctl.dump_addr = ADDR_W'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      cnt_r     <= '0;
      d1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DRAIN) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (issue) begin
        d1_vld_r <= 1'b1;
      end else if (d1_move) begin
        d1_vld_r <= 1'b0;
      end
      if (d1_move) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      d1_idx_r <= ADDR_W'(cnt_r);
    end
    if (d1_move) begin
      out_word_r <= rd_word;
      out_idx_r  <= WIDX_W'(d1_idx_r);
      out_last_r <= (d1_idx_r == ADDR_W'(NUM_WORDS - 1));
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.coeff_word = out_word_r;
  assign out_ch.word_index = out_idx_r;
  assign out_ch.last_word  = out_last_r;

`ifndef NO_ASSERTIONS
  a_final_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    final_acc |-> state_r == ST_RUN)
    else $error("polynomial completed outside the run state");

  a_no_input_with_readout: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !d1_vld_r)
    else $error("input open while readout data is pending");
`endif

endmodule
